@@ rtl/cflc_pkg.sv @@
// shared types and constants for the climate fan level controller
// no dependencies; used by every module of the block
package cflc_pkg;

    // fan level limits
    localparam int LEVEL_MIN  = 30;
    localparam int LEVEL_MAX  = 147;
    localparam int LEVEL_SPAN = LEVEL_MAX - LEVEL_MIN;

    // raw sensor conversion
    localparam int HUM_SCALE   = 1000;
    localparam int TEMP_SCALE  = 1650;
    localparam int TEMP_OFFSET = 400;
    localparam logic [7:0] OVERRIDE_AUTO = 8'hFF;

    // field widths
    localparam int LVL_BITS  = 8;
    localparam int WORD_W    = 16;
    localparam int RH_W      = 10;
    localparam int T_W       = 12;
    localparam int HSPAN_W   = 10;
    localparam int TSPAN_W   = 11;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 3;
    localparam int IN_DATA_W  = 2 * WORD_W;
    localparam int OUT_DATA_W = 40;

    // datapath widths
    localparam int EXC_W   = 14;                 // signed excess over start point
    localparam int MAG_W   = EXC_W - 1;          // excess magnitude
    localparam int SPANK_W = 8;                  // width allotted to LEVEL_SPAN
    localparam int DIV_W   = MAG_W + SPANK_W;    // dividend of the serial divider
    localparam int LVL_W   = DIV_W + 1;          // signed coordinate level
    localparam int CAND_W  = LVL_W + 1;          // signed candidate level
    localparam int CNT_W   = $clog2(DIV_W);

    // item kinds
    localparam logic FUNC_SENSOR = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OVERRIDE   = 3'd0,
        CFG_HUM_START  = 3'd1,
        CFG_HUM_SPAN   = 3'd2,
        CFG_TEMP_START = 3'd3,
        CFG_TEMP_SPAN  = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_T_START,
        ST_T_WAIT,
        ST_H_START,
        ST_H_WAIT,
        ST_DECIDE,
        ST_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic convert;
        logic div_start;
        logic div_sel_h;
        logic second_pass;
        logic store_level;
        logic decide;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic func;
        logic rh_zero;
        logic auto_mode;
        logic div_done;
        logic raise_hit;
        logic out_free;
    } t_stat;

endpackage

@@ rtl/climate_fan_level_controller_core.sv @@
// Climate fan level controller, top level.
// Input words: tuser = item kind (sensor reading or ramp tick), tdata = raw
// humidity word (bits 15:0) and raw temperature word (bits 31:16).
// Output words: one per input word, with duty, target and the stored readings;
// tuser is set when a sensor word updated the readings.
// Configuration: i_cfg_we with i_cfg_idx/i_cfg_data, to be written only while idle;
// the block itself does not enforce this. One word at a time. A ramp tick or a
// rejected or overridden sensor reading goes from conversion straight to its
// result word. A regulated reading runs two serial divisions of 21 steps each on
// the shared divider (temperature, then humidity) before its word is presented;
// when no raise occurs a second pass with lowered thresholds follows.
// The input is ready again the cycle after the result word is loaded.
// A held output word is kept while the receiver stalls; the next input word
// is accepted meanwhile and waits in its final step until the word is taken.
// Reset restores the default configuration (automatic mode) and clears
// target, duty and the stored readings.
// Uses cflc_pkg, cflc_ctrl, cflc_datapath and cflc_div.
module climate_fan_level_controller_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // humidity_word [15:0], temperature_word [31:16]
    input  logic [cflc_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // func
    input  logic                              i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // duty_level [7:0], target_level [15:8], temperature_tenths [27:16],
    // humidity_tenths [37:28], zero padding [39:38]
    output logic [cflc_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    // sample_accepted
    output logic                              o_m_axis_tuser,
    input  logic                              i_cfg_we,
    input  logic [cflc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [cflc_pkg::CFG_W-1:0]        i_cfg_data
);
    import cflc_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    cflc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    cflc_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_func      (i_s_axis_tuser),
        .i_in_data   (i_s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata),
        .o_out_user  (o_m_axis_tuser)
    );

endmodule

@@ rtl/cflc_div.sv @@
// restoring serial divider, one quotient bit per cycle, sign applied at the end
// depends on cflc_pkg
module cflc_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [cflc_pkg::DIV_W-1:0]         i_dividend,
    input  logic [cflc_pkg::TSPAN_W-1:0]       i_divisor,
    input  logic                               i_neg,
    output logic                               o_done,
    output logic signed [cflc_pkg::LVL_W-1:0]  o_quot
);
    import cflc_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [TSPAN_W-1:0]   r_rem;
    logic [DIV_W-1:0]     r_quo;
    logic [TSPAN_W-1:0]   r_dsr;
    logic                 r_neg;

    logic [TSPAN_W:0]     trial;
    logic [TSPAN_W:0]     diff;
    logic                 ge;
    logic [LVL_W-1:0]     quo_ext;

    assign trial = {r_rem, r_quo[DIV_W-1]};
    assign diff  = trial - {1'b0, r_dsr};
    assign ge    = trial >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
            r_neg <= i_neg;
        end else if (r_busy) begin
            r_rem <= ge ? diff[TSPAN_W-1:0] : trial[TSPAN_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], ge};
        end
    end

    // truncation toward zero: divide magnitudes, then negate
    assign quo_ext = {1'b0, r_quo};
    assign o_quot  = r_neg ? $signed(LVL_W'(~quo_ext + LVL_W'(1))) : $signed(quo_ext);
    assign o_done  = r_done;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy && $past(r_busy))
        else $error("divider done without a finished run");

endmodule

@@ rtl/cflc_datapath.sv @@
// datapath: configuration registers, sensor conversion, level calculation,
// target and duty state, output word register; depends on cflc_pkg and cflc_div
module cflc_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_func,
    input  logic [cflc_pkg::IN_DATA_W-1:0]    i_in_data,
    input  logic                              i_cfg_we,
    input  logic [cflc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [cflc_pkg::CFG_W-1:0]        i_cfg_data,
    input  cflc_pkg::t_cmd                    i_cmd,
    output cflc_pkg::t_stat                   o_stat,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [cflc_pkg::OUT_DATA_W-1:0]   o_out_data,
    output logic                              o_out_user
);
    import cflc_pkg::*;

    localparam logic signed [CAND_W-1:0] C_MIN = CAND_W'(LEVEL_MIN);
    localparam logic signed [CAND_W-1:0] C_MAX = CAND_W'(LEVEL_MAX);
    localparam logic [LVL_BITS-1:0] L_MIN = LVL_BITS'(LEVEL_MIN);
    localparam logic [LVL_BITS-1:0] L_MAX = LVL_BITS'(LEVEL_MAX);

    // configuration
    logic [LVL_BITS-1:0]      r_override;
    logic [RH_W-1:0]          r_hum_start;
    logic [HSPAN_W-1:0]       r_hum_span;
    logic signed [T_W-1:0]    r_temp_start;
    logic [TSPAN_W-1:0]       r_temp_span;

    // state
    logic [LVL_BITS-1:0]      r_target, n_target;
    logic [LVL_BITS-1:0]      r_duty, n_duty;
    logic signed [T_W-1:0]    r_last_t;
    logic [RH_W-1:0]          r_last_rh;
    logic                     r_accepted;

    // held item
    logic                     r_func;
    logic [WORD_W-1:0]        r_hw;
    logic [WORD_W-1:0]        r_tw;

    logic signed [LVL_W-1:0]  r_level_t;
    logic signed [LVL_W-1:0]  r_level_h;

    logic                     r_out_valid;
    logic [OUT_DATA_W-1:0]    r_out_data;
    logic                     r_out_user;

    // conversion
    logic [WORD_W-1:0]        hw_sh;
    logic [25:0]              rh_prod;
    logic [RH_W-1:0]          rh_val;
    logic [26:0]              t_prod;
    logic [T_W-1:0]           t_val;

    // excess and divider feed
    logic signed [EXC_W-1:0]  t_ext, tmin_ext, tmin_sh, t_excess;
    logic signed [EXC_W-1:0]  rh_ext, hmin_ext, hmin_sh, h_excess;
    logic signed [EXC_W-1:0]  excess;
    logic [EXC_W-1:0]         mag_full;
    logic [MAG_W-1:0]         mag;
    logic [DIV_W-1:0]         dividend;
    logic [TSPAN_W-1:0]       span_sel;
    logic [TSPAN_W-1:0]       divisor;
    logic                     div_done;
    logic signed [LVL_W-1:0]  div_quot;

    // decision
    logic signed [LVL_W-1:0]  lvl_max;
    logic signed [CAND_W-1:0] cand;
    logic signed [CAND_W-1:0] cur_ext;
    logic                     raise_hit;
    logic                     lower_hit;
    logic [LVL_BITS-1:0]      raise_val;
    logic [LVL_BITS-1:0]      lower_val;
    logic [LVL_BITS-1:0]      duty_dec, duty_inc;
    logic                     out_free;

    assign hw_sh   = {r_hw[WORD_W-3:0], 2'b00};
    assign rh_prod = 26'(hw_sh) * 26'(HUM_SCALE);
    assign rh_val  = rh_prod[25:16];
    assign t_prod  = 27'(r_tw) * 27'(TEMP_SCALE);
    assign t_val   = {1'b0, t_prod[26:16]} - T_W'(TEMP_OFFSET);

    assign t_ext    = {{(EXC_W-T_W){r_last_t[T_W-1]}}, r_last_t};
    assign tmin_ext = {{(EXC_W-T_W){r_temp_start[T_W-1]}}, r_temp_start};
    assign tmin_sh  = tmin_ext >>> 3;
    assign t_excess = t_ext - tmin_ext + (i_cmd.second_pass ? tmin_sh : '0);

    assign rh_ext   = {{(EXC_W-RH_W){1'b0}}, r_last_rh};
    assign hmin_ext = {{(EXC_W-RH_W){1'b0}}, r_hum_start};
    assign hmin_sh  = hmin_ext >>> 3;
    assign h_excess = rh_ext - hmin_ext + (i_cmd.second_pass ? hmin_sh : '0);

    assign excess   = i_cmd.div_sel_h ? h_excess : t_excess;
    assign mag_full = excess[EXC_W-1] ? (~excess + EXC_W'(1)) : excess;
    assign mag      = mag_full[MAG_W-1:0];
    assign dividend = DIV_W'(mag) * DIV_W'(LEVEL_SPAN);
    assign span_sel = i_cmd.div_sel_h ? {1'b0, r_hum_span} : r_temp_span;
    // a zero span counts as one
    assign divisor  = (span_sel == '0) ? TSPAN_W'(1) : span_sel;

    cflc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .i_neg      (excess[EXC_W-1]),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    assign lvl_max   = (r_level_t > r_level_h) ? r_level_t : r_level_h;
    assign cand      = {lvl_max[LVL_W-1], lvl_max} + C_MIN;
    assign cur_ext   = {{(CAND_W-LVL_BITS){1'b0}}, r_target};
    assign raise_hit = ((r_target >= L_MIN) && (cand > cur_ext)) ||
                       ((r_target <  L_MIN) && (cand > C_MIN));
    assign raise_val = (cand > C_MAX) ? L_MAX : cand[LVL_BITS-1:0];
    assign lower_hit = cand < cur_ext;
    assign lower_val = (cand > C_MIN) ? cand[LVL_BITS-1:0] : '0;

    assign duty_dec = r_duty - LVL_BITS'(1);
    assign duty_inc = r_duty + LVL_BITS'(1);

    always_comb begin
        n_duty = r_duty;
        if (r_duty > r_target) begin
            n_duty = (duty_dec < L_MIN) ? '0 : duty_dec;
        end else if (r_duty < r_target) begin
            n_duty = (duty_inc < L_MIN) ? L_MIN : duty_inc;
        end
    end

    always_comb begin
        n_target = r_target;
        if (i_cfg_we && (i_cfg_idx == CFG_OVERRIDE) &&
            (i_cfg_data[LVL_BITS-1:0] != OVERRIDE_AUTO)) begin
            if (i_cfg_data[LVL_BITS-1:0] < L_MIN) begin
                n_target = '0;
            end else if (i_cfg_data[LVL_BITS-1:0] > L_MAX) begin
                n_target = L_MAX;
            end else begin
                n_target = i_cfg_data[LVL_BITS-1:0];
            end
        end else if (i_cmd.decide) begin
            if (!i_cmd.second_pass && raise_hit) begin
                n_target = raise_val;
            end else if (i_cmd.second_pass && lower_hit) begin
                n_target = lower_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_override   <= OVERRIDE_AUTO;
            r_hum_start  <= RH_W'(100);
            r_hum_span   <= HSPAN_W'(300);
            r_temp_start <= T_W'(40);
            r_temp_span  <= TSPAN_W'(50);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OVERRIDE:   r_override   <= i_cfg_data[LVL_BITS-1:0];
                CFG_HUM_START:  r_hum_start  <= i_cfg_data[RH_W-1:0];
                CFG_HUM_SPAN:   r_hum_span   <= i_cfg_data[HSPAN_W-1:0];
                CFG_TEMP_START: r_temp_start <= i_cfg_data[T_W-1:0];
                CFG_TEMP_SPAN:  r_temp_span  <= i_cfg_data[TSPAN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target   <= '0;
            r_duty     <= '0;
            r_last_t   <= '0;
            r_last_rh  <= '0;
            r_accepted <= 1'b0;
        end else begin
            r_target <= n_target;
            if (i_cmd.convert) begin
                r_accepted <= 1'b0;
                if (r_func == FUNC_TICK) begin
                    r_duty <= n_duty;
                end else if (rh_val != '0) begin
                    r_last_t   <= t_val;
                    r_last_rh  <= rh_val;
                    r_accepted <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_func <= i_func;
            r_hw   <= i_in_data[WORD_W-1:0];
            r_tw   <= i_in_data[IN_DATA_W-1:WORD_W];
        end
        if (i_cmd.store_level && div_done) begin
            if (i_cmd.div_sel_h) begin
                r_level_h <= div_quot;
            end else begin
                r_level_t <= div_quot;
            end
        end
    end

    // output word register
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {2'b00, r_last_rh, r_last_t, r_target, r_duty};
            r_out_user <= r_accepted;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_user  = r_out_user;

    assign o_stat.func      = r_func;
    assign o_stat.rh_zero   = (rh_val == '0);
    assign o_stat.auto_mode = (r_override == OVERRIDE_AUTO);
    assign o_stat.div_done  = div_done;
    assign o_stat.raise_hit = raise_hit;
    assign o_stat.out_free  = out_free;

    a_target_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_target == '0 || r_target >= L_MIN) && r_target <= L_MAX)
        else $error("target outside its levels");

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_duty == '0 || r_duty >= L_MIN) && r_duty <= L_MAX)
        else $error("duty outside its levels");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> out_free)
        else $error("output word overwritten before it was taken");

endmodule

@@ rtl/cflc_ctrl.sv @@
// controller state machine: sequences conversion, the two divisions per pass,
// the raise and lower decisions and the output load; depends on cflc_pkg
module cflc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output cflc_pkg::t_cmd    o_cmd,
    input  cflc_pkg::t_stat   i_stat
);
    import cflc_pkg::*;

    t_state r_state, n_state;
    logic   r_pass, n_pass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pass  <= n_pass;
        end
    end

    always_comb begin
        n_state = r_state;
        n_pass  = r_pass;
        o_cmd   = '0;
        o_cmd.second_pass = r_pass;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_pass  = 1'b0;
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                o_cmd.convert = 1'b1;
                if (i_stat.func == FUNC_TICK || i_stat.rh_zero || !i_stat.auto_mode) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_T_START;
                end
            end
            ST_T_START: begin
                o_cmd.div_start = 1'b1;
                n_state = ST_T_WAIT;
            end
            ST_T_WAIT: begin
                o_cmd.store_level = 1'b1;
                if (i_stat.div_done) begin
                    n_state = ST_H_START;
                end
            end
            ST_H_START: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel_h = 1'b1;
                n_state = ST_H_WAIT;
            end
            ST_H_WAIT: begin
                o_cmd.store_level = 1'b1;
                o_cmd.div_sel_h   = 1'b1;
                if (i_stat.div_done) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                o_cmd.decide = 1'b1;
                // no raise: recompute with the lowered thresholds
                if (!r_pass && !i_stat.raise_hit) begin
                    n_pass  = 1'b1;
                    n_state = ST_T_START;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
